// ----- rtl/core/wsclock_page_replacement_macros.svh -----
// assertion macros for the page replacement block
`ifndef WSCLOCK_PAGE_REPLACEMENT_MACROS_SVH
`define WSCLOCK_PAGE_REPLACEMENT_MACROS_SVH
// implication checked every clock, quiet during reset
`define WS_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
// next-cycle implication
`define WS_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

// ----- rtl/core/ws_pkg.sv -----
// shared types and constants for the page replacement block
package ws_pkg;
   localparam int FRAMES = 32;
   localparam int PAGE_W = 6;
   localparam int FRAME_W = 5;
   localparam int CSR_W = 8;
   localparam logic CSR_TAU = 1'b0;
   localparam logic CSR_PERIOD = 1'b1;
   localparam logic [CSR_W-1:0] TAU_RESET = 8'd20;
   localparam logic [CSR_W-1:0] PERIOD_RESET = 8'd8;

   // request passed from front to back
   typedef struct packed {
      logic [PAGE_W-1:0] page;
   } req_type;
endpackage

// ----- rtl/core/ws_front.sv -----
// input stage: request capture into a two-entry queue
module ws_front (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_stall,
   input  ws_pkg::req_type in_req,
   output logic out_valid,
   input  logic out_take,
   output ws_pkg::req_type out_req
);
   ws_pkg::req_type q_ff [2];
   ws_pkg::req_type q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic push;

   assign in_stall = cnt_ff == 2'd2;
   assign push = in_valid && !in_stall;
   assign out_valid = cnt_ff != 2'd0;
   assign out_req = q_ff[0];

   always_comb begin
      q_in = q_ff;
      cnt_in = cnt_ff;
      if (out_take && out_valid) begin
         q_in[0] = q_ff[1];
         cnt_in = cnt_in - 2'd1;
      end
      if (push) begin
         q_in[cnt_in[0]] = in_req;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= 2'd0;
      else cnt_ff <= cnt_in;
      q_ff <= q_in;
   end
endmodule

// ----- rtl/core/ws_back.sv -----
// frame table, lookup, free search and victim scan
`include "wsclock_page_replacement_macros.svh"
module ws_back (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_take,
   input  ws_pkg::req_type in_req,
   input  logic [ws_pkg::CSR_W-1:0] tau,
   input  logic [ws_pkg::CSR_W-1:0] period,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_hit,
   output logic [ws_pkg::FRAME_W-1:0] rsp_frame,
   output logic rsp_evicted_valid,
   output logic [ws_pkg::PAGE_W-1:0] rsp_evicted_page
);
   localparam int FRAMES = ws_pkg::FRAMES;
   localparam int FW = $clog2(FRAMES);
   localparam int CW = $clog2(FRAMES + 1);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001, S_LOOK = 5'b00010, S_SCAN = 5'b00100,
      S_DONE = 5'b01000, S_OUT = 5'b10000
   } state_type;

   state_type st_ff, st_in;
   logic [ws_pkg::PAGE_W-1:0] pg_ff [FRAMES];
   logic [7:0] lu_ff [FRAMES];
   logic [FRAMES-1:0] val_ff, ref_ff;
   logic [CW-1:0] cnt_ff;
   logic [7:0] vclk_ff;
   logic [FW-1:0] hand_ff, pos_ff, slot_ff, old_ff;
   logic [CW-1:0] n_ff;
   logic have_old_ff, found_ff, free_ff, hit_ff, evv_ff;
   logic [8:0] oage_ff;
   logic [ws_pkg::PAGE_W-1:0] page_ff, evp_ff;
   logic [ws_pkg::FRAME_W-1:0] frm_ff;

   logic [8:0] age;
   logic [FW-1:0] pos_nx;
   assign age = {1'b0, vclk_ff} - {1'b0, lu_ff[pos_ff]};
   assign pos_nx = (pos_ff == FW'(FRAMES - 1)) ? '0 : pos_ff + 1'b1;
   assign in_take = st_ff == S_IDLE;
   assign rsp_valid = st_ff == S_OUT;
   assign rsp_hit = hit_ff;
   assign rsp_frame = frm_ff;
   assign rsp_evicted_valid = evv_ff;
   assign rsp_evicted_page = evp_ff;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_IDLE: if (in_valid) st_in = S_LOOK;
         S_LOOK: if (n_ff == CW'(FRAMES)) st_in = (found_ff || free_ff) ? S_DONE : S_SCAN;
         S_SCAN: if (n_ff == CW'(FRAMES)) st_in = S_DONE;
         S_DONE: st_in = S_OUT;
         S_OUT:  if (!rsp_stall) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         val_ff <= '0;
         ref_ff <= '0;
         cnt_ff <= '0;
         vclk_ff <= '0;
         hand_ff <= '0;
      end else begin
         st_ff <= st_in;
         unique case (st_ff)
            S_IDLE: if (in_valid) begin
               page_ff <= in_req.page;
               vclk_ff <= vclk_ff + 8'd1;
               n_ff <= '0;
               pos_ff <= '0;
               found_ff <= 1'b0;
               free_ff <= 1'b0;
            end
            S_LOOK: if (n_ff != CW'(FRAMES)) begin
               // lookup and lowest free frame, one frame per cycle
               if (!found_ff && val_ff[pos_ff] && pg_ff[pos_ff] == page_ff) begin
                  found_ff <= 1'b1;
                  slot_ff <= pos_ff;
               end else if (!found_ff && !free_ff && !val_ff[pos_ff]) begin
                  free_ff <= 1'b1;
                  slot_ff <= pos_ff;
               end
               pos_ff <= pos_nx;
               n_ff <= n_ff + 1'b1;
            end else begin
               pos_ff <= hand_ff;
               n_ff <= '0;
               have_old_ff <= 1'b0;
               slot_ff <= found_ff || free_ff ? slot_ff : hand_ff;
            end
            S_SCAN: if (n_ff != CW'(FRAMES)) begin
               if (ref_ff[pos_ff]) ref_ff[pos_ff] <= 1'b0;
               else if ($signed(age) > $signed({1'b0, tau})) begin
                  slot_ff <= pos_ff;
                  have_old_ff <= 1'b0;
               end else if (!have_old_ff || $signed(age) > $signed(oage_ff)) begin
                  have_old_ff <= 1'b1;
                  oage_ff <= age;
                  old_ff <= pos_ff;
               end
               // an old enough frame ends the scan at once
               n_ff <= (ref_ff[pos_ff] || !($signed(age) > $signed({1'b0, tau}))) ?
                  n_ff + 1'b1 : CW'(FRAMES);
               pos_ff <= pos_nx;
            end else if (have_old_ff) slot_ff <= old_ff;
            S_DONE: begin
               hit_ff <= found_ff;
               frm_ff <= ws_pkg::FRAME_W'(slot_ff);
               evv_ff <= !found_ff && !free_ff;
               evp_ff <= (!found_ff && !free_ff) ? pg_ff[slot_ff] : '0;
               if (!found_ff && !free_ff)
                  hand_ff <= (slot_ff == FW'(FRAMES - 1)) ? '0 : slot_ff + 1'b1;
               if (free_ff && !found_ff) begin
                  val_ff[slot_ff] <= 1'b1;
                  cnt_ff <= cnt_ff + 1'b1;
               end
               pg_ff[slot_ff] <= page_ff;
               lu_ff[slot_ff] <= vclk_ff;
               if (vclk_ff >= period) begin
                  ref_ff <= '0;
                  vclk_ff <= '0;
               end else ref_ff[slot_ff] <= 1'b1;
            end
            S_OUT: ;
            default: ;
         endcase
      end
   end

   `WS_ASSERT_IMP(a_out_stable, clock, reset, rsp_valid && rsp_stall, ##1 rsp_valid)
   `WS_ASSERT_IMP(a_ev_zero, clock, reset, rsp_valid && !rsp_evicted_valid, rsp_evicted_page == '0)
   `WS_ASSERT_IMP(a_hit_noev, clock, reset, rsp_valid && rsp_hit, !rsp_evicted_valid)
   `WS_ASSERT_IMP(a_count, clock, reset, 1'b1, cnt_ff <= CW'(FRAMES))
endmodule

// ----- rtl/core/wsclock_page_replacement.sv -----
// WSClock page replacement: one page reference in, one frame decision out.
// A request is captured by a two-entry front queue; the back end then walks
// all FRAMES frames one per cycle for lookup and free search, and on a miss
// with a full table walks up to FRAMES more for the victim scan, then
// updates the table and holds the response while the receiver stalls.
// tau and period are written through the csr port; the user must write them
// only while the block is idle, which the block itself does not enforce.
module wsclock_page_replacement (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [5:0] req_page_id,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_hit,
   output logic [4:0] rsp_frame,
   output logic rsp_evicted_valid,
   output logic [5:0] rsp_evicted_page,
   input  logic csr_write_enable,
   input  logic csr_index,
   input  logic [7:0] csr_write_data
);
   logic [7:0] tau_ff, period_ff;
   ws_pkg::req_type in_req, q_req;
   logic q_valid, q_take;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tau_ff <= ws_pkg::TAU_RESET;
         period_ff <= ws_pkg::PERIOD_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == ws_pkg::CSR_TAU) tau_ff <= csr_write_data;
         else period_ff <= csr_write_data;
      end
   end

   assign in_req.page = req_page_id;

   ws_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_valid), .in_stall(req_stall),
      .in_req(in_req), .out_valid(q_valid), .out_take(q_take), .out_req(q_req)
   );

   ws_back u_back (
      .clock(clock), .reset(reset), .in_valid(q_valid), .in_take(q_take),
      .in_req(q_req), .tau(tau_ff), .period(period_ff), .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall), .rsp_hit(rsp_hit), .rsp_frame(rsp_frame),
      .rsp_evicted_valid(rsp_evicted_valid), .rsp_evicted_page(rsp_evicted_page)
   );
endmodule
